// ===== hw/rtl/circumcenter_3d_unit_assert.svh =====
// Assertion macros for the checker of the circumcenter unit.
// Each macro expects signals named clock and reset in the scope of its use.
`ifndef CIRCUMCENTER_3D_UNIT_ASSERT_SVH
`define CIRCUMCENTER_3D_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define CC3D_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define CC3D_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also holds across reset.
`define CC3D_ASSERT_ALWAYS_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/cc3d_pkg.sv =====
package cc3d_pkg;

   // Coordinate and derived datapath widths.
   localparam int CW    = 16;            // input coordinate
   localparam int DW    = CW + 1;        // coordinate difference
   localparam int PW    = 2 * DW;        // product of two differences
   localparam int CRW   = PW + 1;        // cross product component
   localparam int CRSQW = 2 * CRW;       // squared cross component
   localparam int CNW   = CRSQW + 2;     // squared cross norm
   localparam int SQW   = 2 * DW + 2;    // squared side length
   localparam int EW    = SQW + 2;       // b2 + c2 - a2 and friends
   localparam int ELW   = EW / 2;        // low split of EW
   localparam int WW    = SQW + 1 + EW;  // barycentric weight
   localparam int WLW   = WW / 2;        // low split of WW
   localparam int SW    = WW + 2;        // weight sum
   localparam int TW    = WW + CW;       // weight times coordinate
   localparam int NW    = TW + 2;        // numerator
   localparam int OW    = 32;            // center coordinate and quotient bits
   localparam int NPW   = NW + 1;        // 2|num| + |sum|
   localparam int DPW   = SW + 1;        // 2|sum|
   localparam int RW    = DPW + OW;      // divider remainder
   localparam int LIMW  = 63;            // limit registers

   localparam int FRONT_STAGES = 10;
   localparam int PT_STAGES    = 7;

   localparam int QAW    = 2;
   localparam int QDEPTH = 1 << QAW;

   localparam int CSRIW = 8;
   localparam int CSRDW = 64;
   localparam logic [CSRIW-1:0] CSR_COLLINEAR_LIMIT  = CSRIW'(0);
   localparam logic [CSRIW-1:0] CSR_WEIGHT_SUM_LIMIT = CSRIW'(1);

   localparam logic [OW-1:0] NEG_LIMIT = {1'b1, {(OW-1){1'b0}}};

   typedef enum logic [1:0] {
      ST_VALID     = 2'd0,
      ST_COLLINEAR = 2'd1,
      ST_WEIGHT    = 2'd2,
      ST_SAT       = 2'd3
   } status_type;

   typedef struct packed {
      logic signed [NW-1:0] num_x;
      logic signed [NW-1:0] num_y;
      logic signed [NW-1:0] num_z;
      logic signed [SW-1:0] wsum;
      status_type           status;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

// ===== hw/rtl/cc3d_front.sv =====
module cc3d_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               adv,
   input  logic                               in_valid,
   input  logic signed [cc3d_pkg::CW-1:0]     pt_in [3][3],
   input  logic [cc3d_pkg::LIMW-1:0]          collinear_limit,
   input  logic [cc3d_pkg::LIMW-1:0]          weight_sum_limit,
   output logic                               out_valid,
   output cc3d_pkg::item_type                 out_item
);
   import cc3d_pkg::*;

   logic [FRONT_STAGES-1:0] fv_ff;
   logic signed [CW-1:0]    pts_ff [PT_STAGES][3][3];
   logic signed [DW-1:0]    v1_ff [3], v2_ff [3], u_ff [3], w_ff [3];
   logic signed [PW-1:0]    m_ff [6], su_ff [3], sw_ff [3], sv_ff [3];
   logic signed [CRW-1:0]   cr_ff [3];
   logic signed [SQW-1:0]   sq_ff [3], sq4_ff [3];
   logic signed [EW-1:0]    e_ff [3];
   logic [CRSQW-1:0]        crsq_ff [3];
   logic [CNW-1:0]          crn_ff;
   logic signed [WW-1:0]    wlo_ff [3], whi_ff [3], wt_ff [3];
   logic                    col6_ff, col7_ff, col8_ff, wflag8_ff;
   logic signed [SW-1:0]    wsum7_ff, wsum8_ff;
   logic signed [TW-1:0]    tlo_ff [3][3], thi_ff [3][3], term_ff [3][3];
   logic [SW-1:0]           wmag;
   item_type                item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fv_ff <= '0;
      end else if (adv) begin
         fv_ff <= {fv_ff[FRONT_STAGES-2:0], in_valid};
      end
   end

   assign wmag = wsum7_ff[SW-1] ? unsigned'(-wsum7_ff) : unsigned'(wsum7_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         pts_ff[0] <= pt_in;
         for (int s = 1; s < PT_STAGES; s++) begin
            pts_ff[s] <= pts_ff[s-1];
         end
         // Edge vectors: v1 = second-first, v2 = mid-first, u = second-mid,
         // w = first-mid.
         for (int k = 0; k < 3; k++) begin
            v1_ff[k] <= DW'(pts_ff[0][1][k]) - DW'(pts_ff[0][0][k]);
            v2_ff[k] <= DW'(pts_ff[0][2][k]) - DW'(pts_ff[0][0][k]);
            u_ff[k]  <= DW'(pts_ff[0][1][k]) - DW'(pts_ff[0][2][k]);
            w_ff[k]  <= DW'(pts_ff[0][0][k]) - DW'(pts_ff[0][2][k]);
            su_ff[k] <= u_ff[k] * u_ff[k];
            sw_ff[k] <= w_ff[k] * w_ff[k];
            sv_ff[k] <= v1_ff[k] * v1_ff[k];
         end
         m_ff[0] <= v1_ff[1] * v2_ff[2];
         m_ff[1] <= v1_ff[2] * v2_ff[1];
         m_ff[2] <= v1_ff[2] * v2_ff[0];
         m_ff[3] <= v1_ff[0] * v2_ff[2];
         m_ff[4] <= v1_ff[0] * v2_ff[1];
         m_ff[5] <= v1_ff[1] * v2_ff[0];
         for (int k = 0; k < 3; k++) begin
            cr_ff[k] <= CRW'(m_ff[2*k]) - CRW'(m_ff[2*k+1]);
         end
         sq_ff[0] <= SQW'(su_ff[0]) + SQW'(su_ff[1]) + SQW'(su_ff[2]);
         sq_ff[1] <= SQW'(sw_ff[0]) + SQW'(sw_ff[1]) + SQW'(sw_ff[2]);
         sq_ff[2] <= SQW'(sv_ff[0]) + SQW'(sv_ff[1]) + SQW'(sv_ff[2]);
         for (int k = 0; k < 3; k++) begin
            crsq_ff[k] <= cr_ff[k] * cr_ff[k];
            sq4_ff[k]  <= sq_ff[k];
         end
         e_ff[0] <= EW'(sq_ff[1]) + EW'(sq_ff[2]) - EW'(sq_ff[0]);
         e_ff[1] <= EW'(sq_ff[2]) + EW'(sq_ff[0]) - EW'(sq_ff[1]);
         e_ff[2] <= EW'(sq_ff[0]) + EW'(sq_ff[1]) - EW'(sq_ff[2]);
         crn_ff <= CNW'(crsq_ff[0]) + CNW'(crsq_ff[1]) + CNW'(crsq_ff[2]);
         // Weights are formed from two half-width partial products.
         for (int j = 0; j < 3; j++) begin
            wlo_ff[j] <= sq4_ff[j] * $signed({1'b0, e_ff[j][ELW-1:0]});
            whi_ff[j] <= sq4_ff[j] * $signed(e_ff[j][EW-1:ELW]);
            wt_ff[j]  <= (whi_ff[j] <<< ELW) + wlo_ff[j];
         end
         col6_ff  <= crn_ff < CNW'(collinear_limit);
         col7_ff  <= col6_ff;
         wsum7_ff <= SW'(wt_ff[0]) + SW'(wt_ff[1]) + SW'(wt_ff[2]);
         for (int j = 0; j < 3; j++) begin
            for (int k = 0; k < 3; k++) begin
               tlo_ff[j][k]  <= $signed({1'b0, wt_ff[j][WLW-1:0]}) * pts_ff[PT_STAGES-1][j][k];
               thi_ff[j][k]  <= $signed(wt_ff[j][WW-1:WLW]) * pts_ff[PT_STAGES-1][j][k];
               term_ff[j][k] <= (thi_ff[j][k] <<< WLW) + tlo_ff[j][k];
            end
         end
         col8_ff   <= col7_ff;
         wsum8_ff  <= wsum7_ff;
         wflag8_ff <= (wsum7_ff == '0) || (wmag < SW'(weight_sum_limit));
         item_ff.num_x <= NW'(term_ff[0][0]) + NW'(term_ff[1][0]) + NW'(term_ff[2][0]);
         item_ff.num_y <= NW'(term_ff[0][1]) + NW'(term_ff[1][1]) + NW'(term_ff[2][1]);
         item_ff.num_z <= NW'(term_ff[0][2]) + NW'(term_ff[1][2]) + NW'(term_ff[2][2]);
         item_ff.wsum  <= wsum8_ff;
         item_ff.status <= col8_ff ? ST_COLLINEAR : (wflag8_ff ? ST_WEIGHT : ST_VALID);
      end
   end

   assign out_valid = fv_ff[FRONT_STAGES-1];
   assign out_item  = item_ff;

endmodule

// ===== hw/rtl/cc3d_queue.sv =====
module cc3d_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  logic                pop,
   input  cc3d_pkg::item_type  in_item,
   output cc3d_pkg::item_type  out_item,
   output cc3d_pkg::qstat_type stat
);
   import cc3d_pkg::*;

   item_type         entries_ff [QDEPTH];
   logic [QAW-1:0]   wptr_ff, rptr_ff;
   logic [QAW:0]     count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (push) wptr_ff <= wptr_ff + 1'b1;
         if (pop)  rptr_ff <= rptr_ff + 1'b1;
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) entries_ff[wptr_ff] <= in_item;
   end

   assign out_item   = entries_ff[rptr_ff];
   assign stat.full  = count_ff == (QAW+1)'(QDEPTH);
   assign stat.empty = count_ff == '0;

endmodule

// ===== hw/rtl/cc3d_back.sv =====
module cc3d_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            adv,
   input  logic                            in_valid,
   input  cc3d_pkg::item_type              in_item,
   output logic                            out_valid,
   output logic signed [cc3d_pkg::OW-1:0]  center_x,
   output logic signed [cc3d_pkg::OW-1:0]  center_y,
   output logic signed [cc3d_pkg::OW-1:0]  center_z,
   output logic [1:0]                      status
);
   import cc3d_pkg::*;

   logic                 v0_ff, v1_ff, rv_ff;
   item_type             it_ff;
   logic signed [NW-1:0] nm [3];
   logic [NW-1:0]        an [3];
   logic [SW-1:0]        ad;
   logic [NPW-1:0]       np1_ff [3];
   logic [DPW-1:0]       dp1_ff;
   logic [2:0]           neg1_ff;
   status_type           st1_ff;

   logic                 dv_ff   [0:OW];
   logic [RW-1:0]        rem_ff  [0:OW][3];
   logic [OW-1:0]        q_ff    [0:OW][3];
   logic [DPW-1:0]       dp_ff   [0:OW];
   logic [2:0]           neg_ff  [0:OW];
   logic [2:0]           ovf_ff  [0:OW];
   status_type           st_ff   [0:OW];

   logic [2:0]           fail;
   logic [OW-1:0]        cval [3];
   status_type           st_fin;
   status_type           st_out_ff;
   logic signed [OW-1:0] cx_ff, cy_ff, cz_ff;

   assign nm[0] = it_ff.num_x;
   assign nm[1] = it_ff.num_y;
   assign nm[2] = it_ff.num_z;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         an[k] = nm[k][NW-1] ? unsigned'(-nm[k]) : unsigned'(nm[k]);
      end
      ad = it_ff.wsum[SW-1] ? unsigned'(-it_ff.wsum) : unsigned'(it_ff.wsum);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff    <= 1'b0;
         v1_ff    <= 1'b0;
         dv_ff[0] <= 1'b0;
      end else if (adv) begin
         v0_ff    <= in_valid;
         v1_ff    <= v0_ff;
         dv_ff[0] <= v1_ff;
      end
   end

   // Rounded quotient is (2|n| + |d|) / (2|d|); the stage that loads the divider also
   // flags quotients of 2^OW or more.
   always_ff @(posedge clock) begin
      if (adv) begin
         it_ff  <= in_item;
         for (int k = 0; k < 3; k++) begin
            np1_ff[k]  <= NPW'({an[k], 1'b0}) + NPW'(ad);
            neg1_ff[k] <= nm[k][NW-1] ^ it_ff.wsum[SW-1];
         end
         dp1_ff <= {ad, 1'b0};
         st1_ff <= it_ff.status;
         for (int k = 0; k < 3; k++) begin
            rem_ff[0][k]    <= RW'(np1_ff[k]);
            q_ff[0][k]      <= '0;
            ovf_ff[0][k]    <= RW'(np1_ff[k]) >= (RW'(dp1_ff) << OW);
         end
         dp_ff[0]  <= dp1_ff;
         neg_ff[0] <= neg1_ff;
         st_ff[0]  <= st1_ff;
      end
   end

   for (genvar t = 0; t < OW; t++) begin : g_div
      logic [RW-1:0] dsh;
      logic [RW:0]   diff [3];

      assign dsh = RW'(dp_ff[t]) << (OW - 1 - t);

      always_comb begin
         for (int k = 0; k < 3; k++) begin
            diff[k] = {1'b0, rem_ff[t][k]} - {1'b0, dsh};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[t+1] <= 1'b0;
         end else if (adv) begin
            dv_ff[t+1] <= dv_ff[t];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            for (int k = 0; k < 3; k++) begin
               rem_ff[t+1][k] <= diff[k][RW] ? rem_ff[t][k] : diff[k][RW-1:0];
               q_ff[t+1][k]   <= {q_ff[t][k][OW-2:0], !diff[k][RW]};
            end
            dp_ff[t+1]  <= dp_ff[t];
            neg_ff[t+1] <= neg_ff[t];
            ovf_ff[t+1] <= ovf_ff[t];
            st_ff[t+1]  <= st_ff[t];
         end
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         fail[k] = ovf_ff[OW][k] |
                   (neg_ff[OW][k] ? (q_ff[OW][k] > NEG_LIMIT) : q_ff[OW][k][OW-1]);
         cval[k] = neg_ff[OW][k] ? (~q_ff[OW][k] + 1'b1) : q_ff[OW][k];
      end
      if (st_ff[OW] != ST_VALID) begin
         st_fin = st_ff[OW];
      end else if (|fail) begin
         st_fin = ST_SAT;
      end else begin
         st_fin = ST_VALID;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
      end else if (adv) begin
         rv_ff <= dv_ff[OW];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         st_out_ff <= st_fin;
         cx_ff     <= (st_fin == ST_VALID) ? signed'(cval[0]) : '0;
         cy_ff     <= (st_fin == ST_VALID) ? signed'(cval[1]) : '0;
         cz_ff     <= (st_fin == ST_VALID) ? signed'(cval[2]) : '0;
      end
   end

   assign out_valid = rv_ff;
   assign center_x  = cx_ff;
   assign center_y  = cy_ff;
   assign center_z  = cz_ff;
   assign status    = st_out_ff;

endmodule

// ===== hw/rtl/circumcenter_3d_unit.sv =====
// Circumcenter of a 3D triangle given by two arc ends and a point on the arc.
// The req_ channel takes one word per triangle: nine signed coordinates.
// A word is taken at a clock edge with req_valid high and req_stall low.
// The rsp_ channel gives one word per request, in order: three signed
// 32-bit center coordinates in the input's fixed-point format and a status
// (0 valid, 1 collinear, 2 weight sum near zero, 3 center saturated).
// Centers read zero unless the status is valid.
// The csr_ channel writes the collinear limit (index 0) and the weight sum
// limit (index 1); csr_ready is always high and other indexes are ignored.
// Throughput is one word per cycle while req_stall stays low. A word passes
// the 10-stage front end, one queue slot and the 36-stage back end, whose
// 32 radix-2 divider stages dominate, on its way to rsp_valid.
// When rsp_stall is high with rsp_valid the back end freezes, while the front
// end keeps accepting until its four-entry queue fills; then req_stall rises.
// Synchronous reset empties every stage and the queue and sets both limits
// to one.
module circumcenter_3d_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [cc3d_pkg::CW-1:0]    req_first_x,
   input  logic signed [cc3d_pkg::CW-1:0]    req_first_y,
   input  logic signed [cc3d_pkg::CW-1:0]    req_first_z,
   input  logic signed [cc3d_pkg::CW-1:0]    req_second_x,
   input  logic signed [cc3d_pkg::CW-1:0]    req_second_y,
   input  logic signed [cc3d_pkg::CW-1:0]    req_second_z,
   input  logic signed [cc3d_pkg::CW-1:0]    req_mid_x,
   input  logic signed [cc3d_pkg::CW-1:0]    req_mid_y,
   input  logic signed [cc3d_pkg::CW-1:0]    req_mid_z,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [cc3d_pkg::OW-1:0]    rsp_center_x,
   output logic signed [cc3d_pkg::OW-1:0]    rsp_center_y,
   output logic signed [cc3d_pkg::OW-1:0]    rsp_center_z,
   output logic [1:0]                        rsp_status,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [cc3d_pkg::CSRIW-1:0]        csr_index,
   input  logic [cc3d_pkg::CSRDW-1:0]        csr_data
);
   import cc3d_pkg::*;

   logic [LIMW-1:0]      col_lim_ff, wsum_lim_ff;
   logic signed [CW-1:0] pts [3][3];
   logic                 front_adv, back_adv, f_valid;
   item_type             f_item, q_item;
   qstat_type            q_stat;

   // Both limits take the low 63 bits of the written word.
   always_ff @(posedge clock) begin
      if (reset) begin
         col_lim_ff  <= LIMW'(1);
         wsum_lim_ff <= LIMW'(1);
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_COLLINEAR_LIMIT:  col_lim_ff  <= csr_data[LIMW-1:0];
            CSR_WEIGHT_SUM_LIMIT: wsum_lim_ff <= csr_data[LIMW-1:0];
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   assign pts[0][0] = req_first_x;
   assign pts[0][1] = req_first_y;
   assign pts[0][2] = req_first_z;
   assign pts[1][0] = req_second_x;
   assign pts[1][1] = req_second_y;
   assign pts[1][2] = req_second_z;
   assign pts[2][0] = req_mid_x;
   assign pts[2][1] = req_mid_y;
   assign pts[2][2] = req_mid_z;

   // The front end holds only when its last stage cannot enter a full queue.
   assign front_adv = !(f_valid && q_stat.full);
   assign req_stall = !front_adv;

   // The back end moves whenever the output register is free or drained.
   assign back_adv = !rsp_valid || !rsp_stall;

   cc3d_front u_front (
      .clock            (clock),
      .reset            (reset),
      .adv              (front_adv),
      .in_valid         (req_valid),
      .pt_in            (pts),
      .collinear_limit  (col_lim_ff),
      .weight_sum_limit (wsum_lim_ff),
      .out_valid        (f_valid),
      .out_item         (f_item)
   );

   cc3d_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (f_valid && front_adv),
      .pop      (back_adv && !q_stat.empty),
      .in_item  (f_item),
      .out_item (q_item),
      .stat     (q_stat)
   );

   cc3d_back u_back (
      .clock     (clock),
      .reset     (reset),
      .adv       (back_adv),
      .in_valid  (!q_stat.empty),
      .in_item   (q_item),
      .out_valid (rsp_valid),
      .center_x  (rsp_center_x),
      .center_y  (rsp_center_y),
      .center_z  (rsp_center_z),
      .status    (rsp_status)
   );

endmodule

// ===== hw/rtl/cc3d_checker.sv =====
`include "circumcenter_3d_unit_assert.svh"

module cc3d_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic signed [cc3d_pkg::CW-1:0]    req_first_x,
   input logic signed [cc3d_pkg::CW-1:0]    req_first_y,
   input logic signed [cc3d_pkg::CW-1:0]    req_first_z,
   input logic signed [cc3d_pkg::CW-1:0]    req_second_x,
   input logic signed [cc3d_pkg::CW-1:0]    req_second_y,
   input logic signed [cc3d_pkg::CW-1:0]    req_second_z,
   input logic signed [cc3d_pkg::CW-1:0]    req_mid_x,
   input logic signed [cc3d_pkg::CW-1:0]    req_mid_y,
   input logic signed [cc3d_pkg::CW-1:0]    req_mid_z,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic signed [cc3d_pkg::OW-1:0]    rsp_center_x,
   input logic signed [cc3d_pkg::OW-1:0]    rsp_center_y,
   input logic signed [cc3d_pkg::OW-1:0]    rsp_center_z,
   input logic [1:0]                        rsp_status,
   input logic                              csr_valid,
   input logic                              csr_ready,
   input logic [cc3d_pkg::CSRIW-1:0]        csr_index,
   input logic [cc3d_pkg::CSRDW-1:0]        csr_data
);
   import cc3d_pkg::*;

   // A stalled result stays offered.
   `CC3D_ASSERT_NEXT(a_rsp_valid_holds, rsp_valid && rsp_stall, rsp_valid, "rsp_valid dropped")

   // A stalled result keeps its payload.
   `CC3D_ASSERT_NEXT(a_rsp_data_holds, rsp_valid && rsp_stall, $stable(rsp_center_x) && $stable(rsp_center_y) && $stable(rsp_center_z) && $stable(rsp_status), "stalled rsp changed")

   // Any outcome other than valid carries a zero center.
   `CC3D_ASSERT_NOW(a_zero_center, rsp_valid && rsp_status != ST_VALID, rsp_center_x == 0 && rsp_center_y == 0 && rsp_center_z == 0, "nonzero center")

   // Reset leaves no result pending.
   `CC3D_ASSERT_ALWAYS_NEXT(a_reset_empty, reset, !rsp_valid, "rsp_valid after reset")

endmodule

bind circumcenter_3d_unit cc3d_checker u_chk (.*);
